### sv/jue_pkg.sv
// Shared types, constants and helper functions for the JSON unicode-escape decoder.
package jue_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned BYTE_IDX_W = $clog2(MAX_BYTES);

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_ESC = 2'd1,
    STAT_NO_LOW  = 2'd2,
    STAT_BAD_LOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_data_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       byte_present;
    logic       run_end;
    logic       string_done;
    status_t    status;
  } out_data_t;

  // One queued command: the results caused by one accepted input byte.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [BYTE_IDX_W-1:0]     last_idx;
    logic                      no_byte;
    logic                      done;
    status_t                   status;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic ok;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [BYTE_IDX_W-1:0]     last_idx;
  } enc_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    case (b) inside
      [8'h30:8'h39]: h.value = b[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: h.value = b[3:0] + 4'd9;
      default: h.ok = 1'b0;
    endcase
    return h;
  endfunction

  // Split a code point into one to four UTF-8 bytes.
  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

endpackage

### sv/json_unicode_escape_to_utf8.sv
// Top level of the JSON unicode-escape to UTF-8 decoder.
//
//   channel  dir  valid      stall      payload
//   input    in   in_valid   in_stall   in_data  (text_byte, final_byte)
//   result   out  out_valid  out_stall  out_data (utf8_byte, byte_present, run_end,
//                                                string_done, status)
//
// The front end takes one text byte per cycle while the command queue has room.
// The back end emits one result per cycle while out_stall is low, so a byte
// producing N results (1 to 4) holds the back end until all N are out; the
// queue depth sets how far the front end runs ahead before in_stall rises.
// Synchronous active-low reset empties the queue and returns to plain text.
// A stall on the result channel holds the output register; the queue keeps
// absorbing input transactions until it is full.
module json_unicode_escape_to_utf8 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jue_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jue_pkg::out_data_t out_data
);

  jue_pkg::push_t q_push;
  jue_pkg::cmd_t  q_head;
  logic           q_empty;
  logic           q_full;
  logic           q_pop;

  // Accept input whenever the queue has a free slot.
  assign in_stall = q_full;

  // Parse escapes and classify each byte into a result command.
  jue_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  // Decouple parsing from emission.
  jue_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Emit the bytes of each command, one transaction per cycle while out_stall is low.
  jue_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/jue_front.sv
// Front end: parses escape sequences and queues one command per producing byte.
module jue_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  jue_pkg::in_data_t in_data,
  input  logic             q_full,
  output jue_pkg::push_t   q_push
);

  typedef enum logic [6:0] {
    ST_PLAIN   = 7'b0000001,
    ST_ESC     = 7'b0000010,
    ST_HEX     = 7'b0000100,
    ST_PAIR_BS = 7'b0001000,
    ST_PAIR_U  = 7'b0010000,
    ST_LHEX    = 7'b0100000,
    ST_HALT    = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hi_r, hi_nxt;

  logic              accept;
  logic [7:0]        b;
  logic              fin;
  jue_pkg::hex_t     dig;
  logic [15:0]       v;
  logic [20:0]       cp;
  jue_pkg::enc_t     enc;
  logic              stop;
  logic              has_byte;
  jue_pkg::status_t  st;
  jue_pkg::cmd_t     cmd;
  logic              push;

  function automatic jue_pkg::status_t cut_status(input state_t s);
    jue_pkg::status_t r;
    case (s)
      ST_ESC, ST_HEX:        r = jue_pkg::STAT_BAD_ESC;
      ST_PAIR_BS, ST_PAIR_U: r = jue_pkg::STAT_NO_LOW;
      ST_LHEX:               r = jue_pkg::STAT_BAD_LOW;
      default:               r = jue_pkg::STAT_OK;
    endcase
    return r;
  endfunction

  assign accept = in_valid && !q_full;
  assign b = in_data.text_byte;
  assign fin = in_data.final_byte;

  always_comb begin
    dig = jue_pkg::hex_value(b);
    v = {acc_r, dig.value};
    cp = (state_r == ST_LHEX) ? 21'h10000 + {1'b0, hi_r, v[9:0]} : {5'd0, v};
    enc = jue_pkg::utf8_encode(cp);
    state_nxt = state_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    hi_nxt = hi_r;
    stop = 1'b0;
    has_byte = 1'b0;
    st = jue_pkg::STAT_OK;
    cmd.bytes = '0;
    cmd.last_idx = '0;
    push = 1'b0;

    if (state_r == ST_HALT) begin
      // Drop everything until the string ends.
      if (fin) begin
        state_nxt = ST_PLAIN;
        acc_nxt = '0;
        cnt_nxt = '0;
        hi_nxt = '0;
      end
    end else begin
      if (b == 8'd0) begin
        stop = 1'b1;
        st = cut_status(state_r);
      end else begin
        case (state_r)
          ST_ESC: begin
            if (b == jue_pkg::CH_U) begin
              state_nxt = ST_HEX;
              acc_nxt = '0;
              cnt_nxt = '0;
            end else begin
              has_byte = 1'b1;
              cmd.bytes[0] = b;
              state_nxt = ST_PLAIN;
            end
          end
          ST_PAIR_BS: begin
            if (b == jue_pkg::CH_BACKSLASH) begin
              state_nxt = ST_PAIR_U;
            end else begin
              stop = 1'b1;
              st = jue_pkg::STAT_NO_LOW;
            end
          end
          ST_PAIR_U: begin
            if (b == jue_pkg::CH_U) begin
              state_nxt = ST_LHEX;
              acc_nxt = '0;
              cnt_nxt = '0;
            end else begin
              stop = 1'b1;
              st = jue_pkg::STAT_NO_LOW;
            end
          end
          ST_HEX, ST_LHEX: begin
            if (!dig.ok) begin
              stop = 1'b1;
              st = (state_r == ST_LHEX) ? jue_pkg::STAT_BAD_LOW : jue_pkg::STAT_BAD_ESC;
            end else if (cnt_r != 2'd3) begin
              acc_nxt = v[11:0];
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              acc_nxt = '0;
              if (state_r == ST_HEX) begin
                if (v == 16'd0 || v[15:10] == 6'b110111) begin
                  stop = 1'b1;
                  st = jue_pkg::STAT_BAD_ESC;
                end else if (v[15:10] == 6'b110110) begin
                  hi_nxt = v[9:0];
                  state_nxt = ST_PAIR_BS;
                end else begin
                  has_byte = 1'b1;
                  cmd.bytes = enc.bytes;
                  cmd.last_idx = enc.last_idx;
                  state_nxt = ST_PLAIN;
                end
              end else begin
                if (v[15:10] != 6'b110111) begin
                  stop = 1'b1;
                  st = jue_pkg::STAT_BAD_LOW;
                end else begin
                  has_byte = 1'b1;
                  cmd.bytes = enc.bytes;
                  cmd.last_idx = enc.last_idx;
                  state_nxt = ST_PLAIN;
                end
              end
            end
          end
          default: begin
            if (b == jue_pkg::CH_BACKSLASH) begin
              state_nxt = ST_ESC;
            end else begin
              has_byte = 1'b1;
              cmd.bytes[0] = b;
            end
          end
        endcase
      end

      // String ends in the middle of an escape.
      if (!stop && fin && state_nxt != ST_PLAIN) begin
        stop = 1'b1;
        st = cut_status(state_nxt);
      end

      if (stop) begin
        has_byte = 1'b0;
        state_nxt = fin ? ST_PLAIN : ST_HALT;
        acc_nxt = '0;
        push = 1'b1;
      end else begin
        push = has_byte || fin;
      end
      if (fin) begin
        acc_nxt = '0;
        cnt_nxt = '0;
        hi_nxt = '0;
        if (!stop) begin
          state_nxt = ST_PLAIN;
        end
      end
    end

    cmd.no_byte = !has_byte;
    cmd.done = stop || fin;
    cmd.status = st;
    q_push.push = accept && push;
    q_push.cmd = cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PLAIN;
      acc_r <= '0;
      cnt_r <= '0;
      hi_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

### sv/jue_fifo.sv
// Command queue between the parser front end and the byte emitter.
module jue_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  jue_pkg::push_t wr,
  input  logic           pop,
  output jue_pkg::cmd_t  head,
  output logic           empty,
  output logic           full
);

  localparam int unsigned PW = jue_pkg::FIFO_PTR_W;

  jue_pkg::cmd_t       mem_r [jue_pkg::FIFO_DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]         count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full = (count_r == (PW+1)'(jue_pkg::FIFO_DEPTH));
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr.push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r + (PW+1)'(wr.push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem_r[wr_ptr_r] <= wr.cmd;
    end
  end

endmodule

### sv/jue_back.sv
// Back end: unpacks queued commands into one registered result per cycle while out_stall is low.
module jue_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jue_pkg::cmd_t      head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output jue_pkg::out_data_t out_data
);

  logic [jue_pkg::BYTE_IDX_W-1:0] idx_r, idx_nxt;
  logic                           valid_r, valid_nxt;
  jue_pkg::out_data_t             data_r, data_nxt;
  logic                           load;
  logic                           last;

  always_comb begin
    load = !q_empty && (!valid_r || !out_stall);
    last = head.no_byte || (idx_r == head.last_idx);
    q_pop = load && last;
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last ? '0 : idx_r + 1'b1;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
    data_nxt.utf8_byte = head.no_byte ? 8'd0 : head.bytes[idx_r];
    data_nxt.byte_present = !head.no_byte;
    data_nxt.run_end = last;
    data_nxt.string_done = last && head.done;
    data_nxt.status = (last && head.done) ? head.status : jue_pkg::STAT_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data = data_r;

endmodule

### test/tb_json_unicode_escape_to_utf8.sv
// Self-checking testbench for the JSON unicode-escape to UTF-8 decoder.
module tb_json_unicode_escape_to_utf8;

  localparam int IDLE_LIMIT   = 1000;  // cycles without any transaction before giving up
  localparam int TAIL_CYCLES  = 16;    // settle time once the expected results are in
  localparam int HOLD_CYCLES  = 60;    // long result-side hold-off, fills the command queue
  localparam int RANDOM_ITEMS = 420;   // decoded (not ignored) text bytes in the random part
  localparam int HOLD_AT      = 150;
  localparam int PAUSE_AT     = 320;

  localparam logic [7:0] CH_BACKSLASH = jue_pkg::CH_BACKSLASH;
  localparam logic [7:0] CH_U         = jue_pkg::CH_U;

  // Decoder phases, mirroring the escape parser.
  typedef enum logic [3:0] {
    PH_TEXT     = 4'd0,
    PH_BSL      = 4'd1,
    PH_D1       = 4'd2,
    PH_D2       = 4'd3,
    PH_D3       = 4'd4,
    PH_D4       = 4'd5,
    PH_WAIT_BSL = 4'd6,
    PH_WAIT_U   = 4'd7,
    PH_L1       = 4'd8,
    PH_L2       = 4'd9,
    PH_L3       = 4'd10,
    PH_L4       = 4'd11
  } dec_phase_t;

  // Kinds of text fragments the random generator strings together.
  typedef enum int {
    TOK_PLAIN,
    TOK_RAW,
    TOK_BMP,
    TOK_PAIR,
    TOK_BAD_HEX,
    TOK_ZERO,
    TOK_LONE_LOW,
    TOK_NO_BSL,
    TOK_NO_U,
    TOK_BAD_LOW,
    TOK_BAD_LOW_HEX,
    TOK_NUL,
    TOK_CUT
  } tok_t;

  typedef struct packed {
    jue_pkg::in_data_t  stim;
    logic               typed;
    jue_pkg::out_data_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  jue_pkg::in_data_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  jue_pkg::out_data_t out_data;

  // Predictor state.
  dec_phase_t pred_phase  = PH_TEXT;
  logic [15:0] pred_acc   = '0;
  logic [9:0]  pred_hi    = '0;
  logic        pred_halted = 1'b0;
  jue_pkg::out_data_t burst [0:4];
  int          burst_n;

  jue_pkg::out_data_t utf8_expect [$];
  logic [7:0]  text_q [$];
  dir_row_t    dir_tab [$];

  logic hold_long = 1'b0;
  logic quick_tx  = 1'b0;
  logic quick_rx  = 1'b0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   n_items, n_useful, n_strings, n_results, n_stops;

  json_unicode_escape_to_utf8 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return {is_digit, value} for one hex character of either case.
  function automatic logic [4:0] hex_nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, 4'(b - 8'h30)};
    if (b >= "A" && b <= "F") return {1'b1, 4'(b - 8'h37)};
    if (b >= "a" && b <= "f") return {1'b1, 4'(b - 8'h57)};
    return 5'd0;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic present);
    jue_pkg::out_data_t r;
    r = '0;
    r.utf8_byte = b;
    r.byte_present = present;
    r.status = jue_pkg::STAT_OK;
    burst[burst_n] = r;
    burst_n++;
  endfunction

  function automatic void push_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      push_byte(cp[7:0], 1'b1);
    end else if (cp < 21'h800) begin
      push_byte(8'hC0 | 8'(cp >> 6), 1'b1);
      push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1);
    end else if (cp < 21'h10000) begin
      push_byte(8'hE0 | 8'(cp >> 12), 1'b1);
      push_byte(8'h80 | {2'b00, cp[11:6]}, 1'b1);
      push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1);
    end else begin
      push_byte(8'hF0 | {5'b0, cp[20:18]}, 1'b1);
      push_byte(8'h80 | {2'b00, cp[17:12]}, 1'b1);
      push_byte(8'h80 | {2'b00, cp[11:6]}, 1'b1);
      push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1);
    end
  endfunction

  // Status reported when the string is cut off in a given phase.
  function automatic jue_pkg::status_t phase_status(dec_phase_t p);
    if (p == PH_BSL || (p >= PH_D1 && p <= PH_D4)) return jue_pkg::STAT_BAD_ESC;
    if (p == PH_WAIT_BSL || p == PH_WAIT_U) return jue_pkg::STAT_NO_LOW;
    if (p >= PH_L1 && p <= PH_L4) return jue_pkg::STAT_BAD_LOW;
    return jue_pkg::STAT_OK;
  endfunction

  function automatic void clear_decoder();
    pred_phase  = PH_TEXT;
    pred_acc    = '0;
    pred_hi     = '0;
    pred_halted = 1'b0;
  endfunction

  // Advance the decoder by one text byte; leave its results in burst[0:burst_n-1].
  function automatic void decode_byte(jue_pkg::in_data_t d);
    logic             stop;
    jue_pkg::status_t st;
    logic [4:0]       hx;
    logic [15:0]      v;
    logic [7:0]       b;
    burst_n = 0;
    b = d.text_byte;
    if (pred_halted) begin
      // Drop everything until the end of the string.
      if (d.final_byte) clear_decoder();
    end else begin
      stop = 1'b0;
      st = jue_pkg::STAT_OK;
      if (b == 8'h00) begin
        stop = 1'b1;
        st = phase_status(pred_phase);
      end else begin
        case (pred_phase)
          PH_TEXT: begin
            if (b == CH_BACKSLASH) pred_phase = PH_BSL;
            else push_byte(b, 1'b1);
          end
          PH_BSL: begin
            if (b == CH_U) begin
              pred_phase = PH_D1;
              pred_acc = '0;
            end else begin
              // Any other escaped character is copied raw.
              push_byte(b, 1'b1);
              pred_phase = PH_TEXT;
            end
          end
          PH_WAIT_BSL: begin
            if (b == CH_BACKSLASH) pred_phase = PH_WAIT_U;
            else begin
              stop = 1'b1;
              st = jue_pkg::STAT_NO_LOW;
            end
          end
          PH_WAIT_U: begin
            if (b == CH_U) begin
              pred_phase = PH_L1;
              pred_acc = '0;
            end else begin
              stop = 1'b1;
              st = jue_pkg::STAT_NO_LOW;
            end
          end
          default: begin
            hx = hex_nibble(b);
            if (!hx[4]) begin
              stop = 1'b1;
              st = (pred_phase >= PH_L1) ? jue_pkg::STAT_BAD_LOW : jue_pkg::STAT_BAD_ESC;
            end else begin
              pred_acc = {pred_acc[11:0], hx[3:0]};
              if (pred_phase == PH_D4) begin
                v = pred_acc;
                pred_acc = '0;
                if (v == 16'h0000 || (v >= 16'hDC00 && v <= 16'hDFFF)) begin
                  stop = 1'b1;
                  st = jue_pkg::STAT_BAD_ESC;
                end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
                  pred_hi = v[9:0];
                  pred_phase = PH_WAIT_BSL;
                end else begin
                  push_code_point({5'b0, v});
                  pred_phase = PH_TEXT;
                end
              end else if (pred_phase == PH_L4) begin
                v = pred_acc;
                pred_acc = '0;
                if (v < 16'hDC00 || v > 16'hDFFF) begin
                  stop = 1'b1;
                  st = jue_pkg::STAT_BAD_LOW;
                end else begin
                  push_code_point(21'h10000 + {1'b0, pred_hi, v[9:0]});
                  pred_phase = PH_TEXT;
                end
              end else begin
                pred_phase = dec_phase_t'(pred_phase + 4'd1);
              end
            end
          end
        endcase
      end

      if (!stop && d.final_byte && pred_phase != PH_TEXT) begin
        stop = 1'b1;
        st = phase_status(pred_phase);
      end

      if (stop) begin
        push_byte(8'h00, 1'b0);
        burst[burst_n-1].string_done = 1'b1;
        burst[burst_n-1].status = st;
        pred_halted = 1'b1;
        pred_phase = PH_TEXT;
        pred_acc = '0;
        n_stops++;
      end else if (d.final_byte) begin
        if (burst_n == 0) push_byte(8'h00, 1'b0);
        burst[burst_n-1].string_done = 1'b1;
      end
      if (burst_n > 0) burst[burst_n-1].run_end = 1'b1;
      if (d.final_byte) clear_decoder();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t row(logic [7:0] b, logic fin, logic typed, logic [7:0] ub,
                                   logic present, logic done, jue_pkg::status_t st);
    dir_row_t r;
    r = '0;
    r.stim.text_byte = b;
    r.stim.final_byte = fin;
    r.typed = typed;
    r.want.utf8_byte = ub;
    r.want.byte_present = present;
    r.want.run_end = typed;
    r.want.string_done = done;
    r.want.status = st;
    return r;
  endfunction

  // Append a backslash-u escape with the first ndig hex digits of v, random case.
  function automatic void put_escape(logic [15:0] v, int ndig);
    logic [3:0] nib;
    text_q.push_back(CH_BACKSLASH);
    text_q.push_back(CH_U);
    for (int i = 0; i < ndig; i++) begin
      nib = v[15-4*i -: 4];
      if (nib < 4'd10) text_q.push_back(8'h30 + 8'(nib));
      else text_q.push_back(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (hex_nibble(b) != 5'd0);
    return b;
  endfunction

  // Offer one text byte, wait for its transaction, then record what it should produce.
  task automatic send_byte(input jue_pkg::in_data_t d, input logic typed,
                           input jue_pkg::out_data_t want);
    int gap;
    gap = (hold_long || quick_tx) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    n_items++;
    if (!pred_halted) n_useful++;
    decode_byte(d);
    // Typed rows carry their own answer; the predictor still tracks the state.
    if (typed) utf8_expect.push_back(want);
    else for (int i = 0; i < burst_n; i++) utf8_expect.push_back(burst[i]);
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (utf8_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off, field-by-field compare
  // ---------------------------------------------------------------------------
  initial begin
    jue_pkg::out_data_t got;
    jue_pkg::out_data_t want;
    int w;
    logic long_now;
    forever begin
      if ($urandom_range(0, 49) == 0) quick_rx = ~quick_rx;
      long_now = hold_long;
      if (long_now) w = HOLD_CYCLES;
      else w = quick_rx ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
        if (long_now) hold_long = 1'b0;
      end
      // A transaction happens at the first edge with out_valid high and no stall.
      do @(posedge clk); while (out_valid !== 1'b1 || rst_n !== 1'b1);
      got = out_data;
      n_results++;
      if (utf8_expect.size() == 0) begin
        $error("output transaction with nothing expected: %h", got);
        mismatches++;
      end else begin
        want = utf8_expect.pop_front();
        if (got.utf8_byte !== want.utf8_byte) begin
          $error("utf8_byte: expected %h, got %h", want.utf8_byte, got.utf8_byte);
          mismatches++;
        end
        if (got.byte_present !== want.byte_present) begin
          $error("byte_present: expected %b, got %b", want.byte_present, got.byte_present);
          mismatches++;
        end
        if (got.run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, got.run_end);
          mismatches++;
        end
        if (got.string_done !== want.string_done) begin
          $error("string_done: expected %b, got %b", want.string_done, got.string_done);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles with no transaction on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $error("no transaction for %0d cycles, %0d results still expected",
           IDLE_LIMIT, utf8_expect.size());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    jue_pkg::in_data_t stim;
    tok_t        tok;
    logic [7:0]  b;
    logic [15:0] v, hi, lo;
    logic        ended;
    logic        did_hold, did_pause;
    int          ntok, t, r, base, cut;

    n_items = 0;
    n_useful = 0;
    n_strings = 0;
    n_results = 0;
    n_stops = 0;
    did_hold = 1'b0;
    did_pause = 1'b0;

    // Directed rows. Typed answers only where they are plain: extremes and stops.
    dir_tab.push_back(row("A",   1'b0, 1'b1, "A",   1'b1, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row(8'h01, 1'b1, 1'b1, 8'h01, 1'b1, 1'b1, jue_pkg::STAT_OK));
    // Largest BMP escape, mixed case: three bytes.
    dir_tab.push_back(row(CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row(CH_U,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("F",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("F",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("f",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("F",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    // Highest high surrogate, then no second escape: missing low surrogate.
    dir_tab.push_back(row(CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row(CH_U,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("D",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("B",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("F",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("f",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("x",   1'b0, 1'b1, 8'h00, 1'b0, 1'b1, jue_pkg::STAT_NO_LOW));
    // Bytes after a stop are dropped, the final one included.
    dir_tab.push_back(row("A",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("A",   1'b1, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    // NUL in plain text, a final NUL dropped after that stop, then a NUL that is also the final byte.
    dir_tab.push_back(row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, jue_pkg::STAT_OK));
    dir_tab.push_back(row(8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row(8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, jue_pkg::STAT_OK));
    // String ending on a lone backslash.
    dir_tab.push_back(row(CH_BACKSLASH, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, jue_pkg::STAT_BAD_ESC));
    // Bad hex digit in the first escape.
    dir_tab.push_back(row(CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row(CH_U,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row("g",   1'b0, 1'b1, 8'h00, 1'b0, 1'b1, jue_pkg::STAT_BAD_ESC));
    dir_tab.push_back(row(8'h20, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    // Escaped backslash as the final byte: copied raw.
    dir_tab.push_back(row(CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, jue_pkg::STAT_OK));
    dir_tab.push_back(row(CH_BACKSLASH, 1'b1, 1'b1, CH_BACKSLASH, 1'b1, 1'b1,
                          jue_pkg::STAT_OK));

    // Hold reset low, then release it for good.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_byte(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    settle();
    n_useful = 0;

    // Random strings: mostly well-formed escapes and pairs, with an error or a
    // cut-off ending a fair share of them.
    while (n_useful < RANDOM_ITEMS) begin
      // Once mid-run, hold the result side off while input keeps coming.
      if (!did_hold && n_useful >= HOLD_AT) begin
        did_hold = 1'b1;
        hold_long = 1'b1;
      end
      // Once mid-run, pause input until the block has drained.
      if (!did_pause && n_useful >= PAUSE_AT) begin
        did_pause = 1'b1;
        settle();
      end
      if ($urandom_range(0, 3) == 0) quick_tx = ~quick_tx;

      text_q.delete();
      ntok = $urandom_range(1, 6);
      ended = 1'b0;
      for (t = 0; t < ntok && !ended; t++) begin
        r = $urandom_range(0, 99);
        if (r < 28) tok = TOK_PLAIN;
        else if (r < 38) tok = TOK_RAW;
        else if (r < 62) tok = TOK_BMP;
        else if (r < 80) tok = TOK_PAIR;
        else tok = tok_t'($urandom_range(TOK_BAD_HEX, TOK_CUT));

        // Surrogates, with the range ends now and then.
        if ($urandom_range(0, 4) == 0) hi = $urandom_range(0, 1) ? 16'hD800 : 16'hDBFF;
        else hi = 16'($urandom_range(16'hD800, 16'hDBFF));
        if ($urandom_range(0, 4) == 0) lo = $urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF;
        else lo = 16'($urandom_range(16'hDC00, 16'hDFFF));

        case (tok)
          TOK_PLAIN: begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_BACKSLASH);
            text_q.push_back(b);
          end
          TOK_RAW: begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_U);
            text_q.push_back(CH_BACKSLASH);
            text_q.push_back(b);
          end
          TOK_BMP: begin
            // Hit each of the one- to three-byte UTF-8 lengths and their boundaries.
            case ($urandom_range(0, 3))
              0: begin
                case ($urandom_range(0, 7))
                  0: v = 16'h0001;
                  1: v = 16'h007F;
                  2: v = 16'h0080;
                  3: v = 16'h07FF;
                  4: v = 16'h0800;
                  5: v = 16'hD7FF;
                  6: v = 16'hE000;
                  default: v = 16'hFFFF;
                endcase
              end
              1: v = 16'($urandom_range(1, 16'h7F));
              2: v = 16'($urandom_range(16'h80, 16'h7FF));
              default: begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
              end
            endcase
            put_escape(v, 4);
          end
          TOK_PAIR: begin
            put_escape(hi, 4);
            put_escape(lo, 4);
          end
          TOK_BAD_HEX: begin
            put_escape(16'($urandom), $urandom_range(0, 3));
            text_q.push_back(pick_non_hex());
          end
          TOK_ZERO:     put_escape(16'h0000, 4);
          TOK_LONE_LOW: put_escape(lo, 4);
          TOK_NO_BSL: begin
            put_escape(hi, 4);
            do b = 8'($urandom_range(1, 255)); while (b == CH_BACKSLASH);
            text_q.push_back(b);
          end
          TOK_NO_U: begin
            put_escape(hi, 4);
            text_q.push_back(CH_BACKSLASH);
            do b = 8'($urandom_range(1, 255)); while (b == CH_U);
            text_q.push_back(b);
          end
          TOK_BAD_LOW: begin
            put_escape(hi, 4);
            v = 16'($urandom);
            if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h2000;
            put_escape(v, 4);
          end
          TOK_BAD_LOW_HEX: begin
            put_escape(hi, 4);
            put_escape(16'($urandom), $urandom_range(0, 3));
            text_q.push_back(pick_non_hex());
          end
          default: begin
            // Truncate a surrogate pair anywhere: a NUL after it, or the end of
            // the string on it, lands in every phase of the parser.
            base = text_q.size();
            put_escape(hi, 4);
            put_escape(lo, 4);
            cut = (tok == TOK_NUL) ? $urandom_range(0, 11) : $urandom_range(1, 11);
            while (text_q.size() > base + cut) void'(text_q.pop_back());
            if (tok == TOK_NUL) text_q.push_back(8'h00);
          end
        endcase

        if (tok >= TOK_BAD_HEX) begin
          ended = 1'b1;
          // Trailing noise after a stop is dropped by the block.
          if (tok != TOK_CUT) begin
            repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
      end

      for (int i = 0; i < text_q.size(); i++) begin
        stim.text_byte = text_q[i];
        stim.final_byte = (i == text_q.size() - 1);
        send_byte(stim, 1'b0, '0);
      end
      n_strings++;
    end

    settle();
    $display("Covered %0d text bytes: %0d directed, the rest in %0d random strings,",
             n_items, dir_tab.size(), n_strings);
    $display("%0d early stops or NUL ends, %0d output transactions compared",
             n_stops, n_results);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### json_unicode_escape_to_utf8.f
sv/jue_pkg.sv
sv/jue_front.sv
sv/jue_fifo.sv
sv/jue_back.sv
sv/json_unicode_escape_to_utf8.sv
test/tb_json_unicode_escape_to_utf8.sv
